// ===== rtl/sclp_pkg.sv =====
// Package: shared types, constants and helpers for the serial command line parser.
`default_nettype none
package sclp_pkg;
  localparam int MaxLineDefault = 64;

  localparam logic [3:0] EV_IGNORED   = 4'd0;
  localparam logic [3:0] EV_HELP      = 4'd1;
  localparam logic [3:0] EV_GET_TEMP  = 4'd2;
  localparam logic [3:0] EV_GET_RANGE = 4'd3;
  localparam logic [3:0] EV_GET_ALERT = 4'd4;
  localparam logic [3:0] EV_LOW_SET   = 4'd5;
  localparam logic [3:0] EV_LOW_REJ   = 4'd6;
  localparam logic [3:0] EV_HIGH_SET  = 4'd7;
  localparam logic [3:0] EV_HIGH_REJ  = 4'd8;
  localparam logic [3:0] EV_INVALID   = 4'd9;
  localparam logic [3:0] EV_UNKNOWN   = 4'd10;
  localparam logic [3:0] EV_TOO_LONG  = 4'd11;

  localparam logic [23:0] CapMag = 24'h800000;
  localparam logic [23:0] PosMax = 24'h7FFFFF;

  typedef enum logic [2:0] {
    PH_BEFORE, PH_SIGN, PH_INT, PH_DOT, PH_FRAC, PH_DONE, PH_FAIL
  } num_phase_t;

  // queue entry: one byte plus the action the back end must take
  typedef struct packed {
    logic        has_event;
    logic [3:0]  ev;
    logic        need_check;   // set command: compare against limits
    logic        is_low;
    logic        negative;
    logic [23:0] mag;
    logic [7:0]  rx_byte;
    logic [23:0] low_limit;
    logic [23:0] high_limit;
  } cmd_req_t;

  // expected command text, uppercase; index k, position i
  function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [3:0] i);
    logic [8*9-1:0] s;
    begin
      case (k)
        3'd0: s = {"HELP", 40'h0};
        3'd1: s = {"GET TEMP", 8'h0};
        3'd2: s = "GET RANGE";
        3'd3: s = "GET ALERT";
        3'd4: s = {"SET TL ", 16'h0};
        default: s = {"SET TH ", 16'h0};
      endcase
      cmd_char = (i < 4'd9) ? s[8*(8-i) +: 8] : 8'h00;
    end
  endfunction

  function automatic logic [3:0] cmd_len(input logic [2:0] k);
    case (k)
      3'd0: cmd_len = 4'd4;
      3'd1: cmd_len = 4'd8;
      3'd2, 3'd3: cmd_len = 4'd9;
      default: cmd_len = 4'd7;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/serial_command_line_parser.sv =====
// Top level: serial command line parser.
// One received byte per request; each gives an echo result and, at a line end or
// an overlong line, a command event. While the output drains and no event is owed,
// a byte is taken every cycle; a byte that ends a line gives echo, then event.
// The echo passes through the queue register and then the output register.
`default_nettype none
module serial_command_line_parser
  import sclp_pkg::*;
#(
  parameter int MAX_LINE = MaxLineDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // rx_byte[7:0], low_limit[31:8], high_limit[55:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // echo_byte[7:0], event_res[11:8], value[35:12], 0
  output logic             m_tuser,  // kind
  output logic             m_tlast
);
  cmd_req_t   q_data;
  logic       q_valid, q_ready;
  logic [7:0] echo_byte;
  logic [3:0] event_res;
  logic [23:0] value;

  sclp_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .rx_byte(s_tdata[7:0]), .low_limit(s_tdata[31:8]), .high_limit(s_tdata[55:32]),
    .q_valid, .q_ready, .q_data
  );

  sclp_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .echo_byte, .event_res, .value, .kind(m_tuser), .last(m_tlast)
  );

  assign m_tdata = {4'b0000, value, event_res, echo_byte};
endmodule
`default_nettype wire

// ===== rtl/sclp_front.sv =====
// Front end: tracks line state per byte and classifies line ends and overlong lines.
`default_nettype none
module sclp_front
  import sclp_pkg::*;
#(
  parameter int MAX_LINE = MaxLineDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [23:0] low_limit,
  input  wire logic [23:0] high_limit,
  output logic             q_valid,
  input  wire logic        q_ready,
  output cmd_req_t         q_data
);
  localparam int LW = $clog2(MAX_LINE + 1);

  logic             mode;
  logic [LW-1:0]    len;
  logic [2:0]       head;
  logic [5:0]       cand;
  num_phase_t       phase;
  logic             neg;
  logic [23:0]      acc;
  logic [1:0]       fcnt;

  logic [5:0]       cand_next;
  num_phase_t       phase_next;
  logic             neg_next;
  logic [23:0]      acc_next;
  logic [1:0]       fcnt_next;
  logic [2:0]       head_next;
  cmd_req_t         req;

  logic       eol, dig;
  logic [7:0] up;
  logic [3:0] d;
  logic       accept;
  logic [28:0] sum;
  logic [28:0] base, addv;
  logic        do_add;

  assign in_ready = !q_valid || q_ready;
  assign accept   = in_valid && in_ready;
  assign eol = (rx_byte == 8'h0D) || (rx_byte == 8'h0A);
  assign up  = (rx_byte >= "a" && rx_byte <= "z") ? rx_byte - 8'd32 : rx_byte;
  assign dig = rx_byte >= "0" && rx_byte <= "9";
  assign d   = rx_byte[3:0];

  // absorb byte into a line (starting fresh when idle)
  always_comb begin
    logic [LW-1:0] i;
    logic [5:0]    c0;
    num_phase_t    p0;
    logic          n0;
    logic [23:0]   a0;
    logic [1:0]    f0;
    logic [2:0]    h0;
    i  = mode ? len : '0;
    c0 = mode ? cand : 6'h3F;
    p0 = mode ? phase : PH_BEFORE;
    n0 = mode ? neg : 1'b0;
    a0 = mode ? acc : 24'd0;
    f0 = mode ? fcnt : 2'd0;
    h0 = mode ? head : 3'd0;
    head_next = h0;
    if (i == '0) begin
      if (rx_byte == "#") head_next[0] = 1'b1;
      if (rx_byte == "/") head_next[1] = 1'b1;
    end else if (i == LW'(1) && rx_byte == "/" && h0[1]) begin
      head_next[2] = 1'b1;
    end
    cand_next = c0;
    for (int k = 0; k < 6; k++) begin
      if (c0[k]) begin
        if (i < LW'(cmd_len(3'(k)))) begin
          if (cmd_char(3'(k), i[3:0]) != up) cand_next[k] = 1'b0;
        end else if (k < 4) begin
          cand_next[k] = 1'b0;
        end
      end
    end
    phase_next = p0;
    neg_next   = n0;
    fcnt_next  = f0;
    base = '0;
    addv = '0;
    do_add = 1'b0;
    if (i >= LW'(7) && (c0[5:4] != 2'b00)) begin
      case (p0)
        PH_BEFORE, PH_SIGN: begin
          if (p0 == PH_BEFORE && (rx_byte == 8'h20 || rx_byte == 8'h09 ||
              rx_byte == 8'h0B || rx_byte == 8'h0C)) begin
            phase_next = p0;
          end else if (p0 == PH_BEFORE && (rx_byte == "+" || rx_byte == "-")) begin
            neg_next = rx_byte == "-";
            phase_next = PH_SIGN;
          end else if (dig) begin
            do_add = 1'b1;
            addv = 29'(d) * 29'd100;
            phase_next = PH_INT;
          end else if (rx_byte == ".") begin
            phase_next = PH_DOT;
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_INT: begin
          if (dig) begin
            do_add = 1'b1;
            base = {a0, 3'b000} + {2'b00, a0, 1'b0};
            addv = 29'(d) * 29'd100;
          end else begin
            phase_next = (rx_byte == ".") ? PH_FRAC : PH_DONE;
          end
        end
        PH_DOT, PH_FRAC: begin
          if (dig) begin
            if (f0 == 2'd0) begin
              do_add = 1'b1; base = 29'(a0); addv = 29'(d) * 29'd10;
            end else if (f0 == 2'd1) begin
              do_add = 1'b1; base = 29'(a0); addv = 29'(d);
            end
            if (f0 < 2'd2) fcnt_next = f0 + 2'd1;
            phase_next = PH_FRAC;
          end else begin
            phase_next = (p0 == PH_DOT) ? PH_FAIL : PH_DONE;
          end
        end
        default: phase_next = p0;
      endcase
    end
    sum = base + addv;
    if (do_add) acc_next = (sum > 29'(CapMag)) ? CapMag : sum[23:0];
    else        acc_next = a0;
  end

  // classify the request
  always_comb begin
    req = '0;
    req.rx_byte = rx_byte;
    req.low_limit = low_limit;
    req.high_limit = high_limit;
    req.negative = neg;
    req.mag = acc;
    req.is_low = cand[4];
    if (mode && eol) begin
      req.has_event = 1'b1;
      if (head[0]) req.ev = EV_IGNORED;
      else if (len <= LW'(2)) req.ev = EV_UNKNOWN;
      else if (head[2]) req.ev = EV_IGNORED;
      else if (cand[0] && len == LW'(4)) req.ev = EV_HELP;
      else if (cand[1] && len == LW'(8)) req.ev = EV_GET_TEMP;
      else if (cand[2] && len == LW'(9)) req.ev = EV_GET_RANGE;
      else if (cand[3] && len == LW'(9)) req.ev = EV_GET_ALERT;
      else if (cand[5:4] == 2'b00 || len < LW'(7)) req.ev = EV_UNKNOWN;
      else if (!(phase == PH_INT || phase == PH_FRAC || phase == PH_DONE))
        req.ev = EV_INVALID;
      else req.need_check = 1'b1;
    end else if (mode && len >= LW'(MAX_LINE - 1)) begin
      req.has_event = 1'b1;
      req.ev = EV_TOO_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      len <= '0;
      head <= '0;
      cand <= 6'h3F;
      phase <= PH_BEFORE;
      neg <= 1'b0;
      acc <= '0;
      fcnt <= '0;
      q_valid <= 1'b0;
    end else begin
      if (accept) begin
        q_valid <= 1'b1;
        q_data <= req;
        if (req.has_event) begin
          mode <= 1'b0;
        end else if (!(eol && !mode)) begin
          mode  <= 1'b1;
          len   <= (mode ? len : '0) + LW'(1);
          head  <= head_next;
          cand  <= cand_next;
          phase <= phase_next;
          neg   <= neg_next;
          acc   <= acc_next;
          fcnt  <= fcnt_next;
        end
      end else if (q_ready) begin
        q_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(MAX_LINE - 1)) else $error("line length overflow");
  a_acc_cap: assert property (@(posedge clk) disable iff (rst)
    acc <= CapMag) else $error("accumulator above cap");
  a_idle_event: assert property (@(posedge clk) disable iff (rst)
    accept && !mode |-> !req.has_event) else $error("event while idle");
`endif
endmodule
`default_nettype wire

// ===== rtl/sclp_back.sv =====
// Back end: limit check, then emits echo and event results.
`default_nettype none
module sclp_back
  import sclp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire cmd_req_t    q_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       echo_byte,
  output logic [3:0]       event_res,
  output logic [23:0]      value,
  output logic             kind,
  output logic             last
);
  logic       pend;     // event still owed after the echo
  logic [3:0] pend_ev;
  logic [23:0] pend_val;
  logic [3:0] ev;
  logic [23:0] v;
  logic       take, free;

  always_comb begin
    v = '0;
    ev = q_data.ev;
    if (q_data.need_check) begin
      if (q_data.negative) v = 24'(-q_data.mag);
      else v = (q_data.mag > PosMax) ? PosMax : q_data.mag;
      if (q_data.is_low)
        ev = ($signed(v) < $signed(q_data.high_limit)) ? EV_LOW_SET : EV_LOW_REJ;
      else
        ev = ($signed(v) > $signed(q_data.low_limit)) ? EV_HIGH_SET : EV_HIGH_REJ;
    end
  end

  assign free = !out_valid || out_ready;
  assign q_ready = free && !(pend || (out_valid && kind == 1'b0 && !last));
  assign take = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else if (free) begin
      if (out_valid && !kind && !last) begin
        out_valid <= 1'b1;
        kind <= 1'b1;
        echo_byte <= '0;
        event_res <= pend_ev;
        value <= pend_val;
        last <= 1'b1;
        pend <= 1'b0;
      end else if (take) begin
        out_valid <= 1'b1;
        kind <= 1'b0;
        echo_byte <= q_data.rx_byte;
        event_res <= '0;
        value <= '0;
        last <= !q_data.has_event;
        pend <= q_data.has_event;
        pend_ev <= ev;
        pend_val <= v;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_pend_echo: assert property (@(posedge clk) disable iff (rst)
    pend |-> out_valid && !kind) else $error("event owed without echo");
  a_event_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> last) else $error("event not last");
  a_pend_stall: assert property (@(posedge clk) disable iff (rst)
    pend |-> !q_ready) else $error("request taken while event owed");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_serial_command_line_parser.sv =====
// Testbench for the serial command line parser: byte stream in, echoes and command events out.
`timescale 1ns / 100ps
`default_nettype none
import sclp_pkg::*;

class parser_scoreboard;
  typedef struct packed {
    logic        kind;
    logic [7:0]  echo;
    logic [3:0]  ev;
    logic [23:0] value;
    logic        last;
  } result_t;

  localparam int MaxLen = 64;

  bit          receiving;
  int          len;
  bit          hash_head, slash_head, dslash_head;
  logic [5:0]  live;
  num_phase_t  phase;
  bit          neg;
  int unsigned mag;
  int          frac_cnt;
  result_t     pending[$];
  int          errors;

  function void clear_line();
    len = 0; hash_head = 0; slash_head = 0; dslash_head = 0;
    live = 6'h3F; phase = PH_BEFORE; neg = 0; mag = 0; frac_cnt = 0;
  endfunction

  function new();
    receiving = 0; errors = 0; clear_line();
  endfunction

  function void sat_add(int unsigned base, int unsigned add);
    int unsigned v;
    v = base + add;
    mag = (v > 32'h800000) ? 32'h800000 : v;
  endfunction

  function void feed_digit(logic [7:0] c);
    bit dig;
    int unsigned d;
    dig = (c >= "0" && c <= "9");
    d = c - "0";
    case (phase)
      PH_BEFORE, PH_SIGN: begin
        if (phase == PH_BEFORE && (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C)) ;
        else if (phase == PH_BEFORE && (c == "+" || c == "-")) begin
          neg = (c == "-"); phase = PH_SIGN;
        end else if (dig) begin
          sat_add(0, d * 100); phase = PH_INT;
        end else if (c == ".") phase = PH_DOT;
        else phase = PH_FAIL;
      end
      PH_INT: begin
        if (dig) sat_add(mag * 10, d * 100);
        else phase = (c == ".") ? PH_FRAC : PH_DONE;
      end
      PH_DOT, PH_FRAC: begin
        if (dig) begin
          if (frac_cnt == 0) sat_add(mag, d * 10);
          else if (frac_cnt == 1) sat_add(mag, d);
          if (frac_cnt < 2) frac_cnt++;
          phase = PH_FRAC;
        end else phase = (phase == PH_DOT) ? PH_FAIL : PH_DONE;
      end
      default: ;
    endcase
  endfunction

  function void take_char(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (len == 0) begin
      if (c == "#") hash_head = 1;
      if (c == "/") slash_head = 1;
    end else if (len == 1 && c == "/" && slash_head) dslash_head = 1;
    for (int k = 0; k < 6; k++) begin
      if (!live[k]) continue;
      if (len < cmd_len(k[2:0])) begin
        if (cmd_char(k[2:0], len[3:0]) != u) live[k] = 0;
      end else if (k < 4) live[k] = 0;
    end
    if (len >= 7 && (live & 6'h30) != 0) feed_digit(c);
    len++;
  endfunction

  function logic [3:0] close_line(logic signed [23:0] lo, logic signed [23:0] hi,
                                  output logic signed [23:0] v);
    v = 0;
    if (hash_head) return EV_IGNORED;
    if (len <= 2) return EV_UNKNOWN;
    if (dslash_head) return EV_IGNORED;
    for (int k = 0; k < 4; k++)
      if (live[k] && len == cmd_len(k[2:0])) return 4'(k + 1);
    if ((live & 6'h30) == 0 || len < 7) return EV_UNKNOWN;
    if (!(phase inside {PH_INT, PH_FRAC, PH_DONE})) return EV_INVALID;
    if (neg) v = -$signed(mag[24:0]);
    else v = (mag > 32'h7FFFFF) ? 24'h7FFFFF : mag[23:0];
    if (live[4]) return (v < hi) ? EV_LOW_SET : EV_LOW_REJ;
    return (v > lo) ? EV_HIGH_SET : EV_HIGH_REJ;
  endfunction

  function void note_request(logic [7:0] c, logic [23:0] lo, logic [23:0] hi);
    bit eol;
    int ev;
    logic signed [23:0] v;
    result_t r;
    eol = (c == 8'h0D || c == 8'h0A);
    ev = -1; v = 0;
    if (!receiving) begin
      if (!eol) begin
        clear_line(); receiving = 1; take_char(c);
      end
    end else if (eol) begin
      ev = close_line(lo, hi, v); receiving = 0;
    end else if (len >= MaxLen - 1) begin
      ev = EV_TOO_LONG; receiving = 0;
    end else take_char(c);
    r = '{1'b0, c, 4'd0, 24'd0, ev < 0};
    pending.push_back(r);
    if (ev >= 0) pending.push_back('{1'b1, 8'd0, 4'(ev), v, 1'b1});
  endfunction

  function void check_result(logic kind, logic [39:0] data, logic last);
    result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result kind=%0d data=%h", kind, data);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (kind !== e.kind) begin
      $error("kind exp %0d got %0d", e.kind, kind); errors++;
    end
    if (data[7:0] !== e.echo) begin
      $error("echo_byte exp %h got %h", e.echo, data[7:0]); errors++;
    end
    if (data[11:8] !== e.ev) begin
      $error("event_res exp %0d got %0d", e.ev, data[11:8]); errors++;
    end
    if (data[35:12] !== e.value) begin
      $error("value exp %0d got %0d", $signed(e.value), $signed(data[35:12])); errors++;
    end
    if (data[39:36] !== 4'd0) begin
      $error("pad exp 0 got %h", data[39:36]); errors++;
    end
    if (last !== e.last) begin
      $error("last exp %0d got %0d", e.last, last); errors++;
    end
  endfunction
endclass

module tb_serial_command_line_parser;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  parser_scoreboard sb;
  int idle_cycles;
  bit drain_burst;
  int bytes_sent;

  always #10 clk = ~clk;

  serial_command_line_parser u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  logic [23:0] lo_lim, hi_lim;
  bit no_gaps;

  task automatic send_byte(logic [7:0] c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (!no_gaps && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {hi_lim, lo_lim, c};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(c, lo_lim, hi_lim);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic pick_limits();
    case ($urandom_range(0, 3))
      0: begin lo_lim = 24'h800000; hi_lim = 24'h7FFFFF; end
      1: begin
        lo_lim = 24'($urandom_range(0, 3000) - 1000);
        hi_lim = 24'($urandom_range(0, 5000));
      end
      default: begin lo_lim = 24'($urandom); hi_lim = 24'($urandom); end
    endcase
  endtask

  function automatic string case_mix(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(0, 1)) r[i] = r[i] + 8'd32;
    return r;
  endfunction

  function automatic string rand_number();
    string r;
    int n;
    r = "";
    repeat ($urandom_range(0, 2)) r = {r, ($urandom_range(0, 1) ? " " : "\t")};
    case ($urandom_range(0, 3))
      0: r = {r, "-"};
      1: r = {r, "+"};
      default: ;
    endcase
    n = $urandom_range(0, 3) == 0 ? $urandom_range(6, 12) : $urandom_range(0, 4);
    repeat (n) r = {r, string'(8'("0" + $urandom_range(0, 9)))};
    if ($urandom_range(0, 1)) begin
      r = {r, "."};
      repeat ($urandom_range(0, 4)) r = {r, string'(8'("0" + $urandom_range(0, 9)))};
    end
    case ($urandom_range(0, 5))
      0: r = {r, "e5"};
      1: r = {r, "x"};
      2: r = {r, " junk"};
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_random_line();
    string s;
    logic [7:0] eol;
    eol = $urandom_range(0, 1) ? 8'h0D : 8'h0A;
    case ($urandom_range(0, 11))
      0: s = "HELP";
      1: s = "GET TEMP";
      2: s = "GET RANGE";
      3: s = "GET ALERT";
      4, 5: s = {"SET TL ", rand_number()};
      6, 7: s = {"SET TH ", rand_number()};
      8: s = ($urandom_range(0, 1) ? "# note" : "//x y");
      9: begin
        s = "";
        repeat ($urandom_range(1, 10)) s = {s, string'(8'($urandom_range(0, 255)))};
        for (int i = 0; i < s.len(); i++) if (s[i] == 8'h0D || s[i] == 8'h0A) s[i] = "z";
      end
      10: s = {"GET T", string'(8'($urandom_range(0, 255)))};
      default: begin
        s = "SET TL ";
        repeat ($urandom_range(57, 70)) s = {s, "9"};
      end
    endcase
    s = case_mix(s);
    if ($urandom_range(0, 7) == 0) pick_limits();
    send_text(s);
    send_byte(eol);
    if ($urandom_range(0, 5) == 0) send_byte($urandom_range(0, 1) ? 8'h0D : 8'h0A);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      m_tready <= 0;
    end else if (m_tready && m_tvalid) begin
      if (drain_burst) m_tready <= 1;
      else begin
        idle_cycles <= $urandom_range(0, 12);
        m_tready <= 0;
      end
    end else m_tready <= 1;
  end

  int stuck;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > 4000) begin
      $display("serial_command_line_parser: mismatch");
      $finish;
    end
  end

  initial begin
    string directed[$];
    sb = new();
    idle_cycles = 0; drain_burst = 0; bytes_sent = 0; stuck = 0;
    no_gaps = 0;
    lo_lim = 24'd1000; hi_lim = 24'd3000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    directed = '{"help\r", "GET TEMP\n", "Get Range\r", "get alert\n", "\r",
                 "SET TL 12.345\r", "SET TH -7.5\n", "set tl 99999999\r",
                 "SET TH -99999999\r", "SET TL \r", "SET TL\r", "SET TH x\r",
                 "# c\r", "//ab\n", "//\r", "a\r", "ab\n", "SET TL .\r",
                 "SET TL  +.5e3\r", "HELPX\r"};
    foreach (directed[i]) send_text(directed[i]);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h0A);
    repeat (70) send_byte("A");
    send_byte(8'h0D);

    drain_burst = 1; no_gaps = 1;
    repeat (15) send_random_line();
    drain_burst = 0; no_gaps = 0;
    while (bytes_sent < 840) begin
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_random_line();
      if ($urandom_range(0, 20) == 0) drain_burst = ~drain_burst;
    end
    s_tvalid <= 0;
    drain_burst = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("serial_command_line_parser: match");
    else
      $display("serial_command_line_parser: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
